// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the two-way shared stack.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks that an expression holds at every clock edge outside reset.
`define TWS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");
// Checks that a condition is followed by a consequence in the next cycle.
`define TWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence violated");
`else
`define TWS_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define TWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/tws_pkg.sv -----
// Package with types, constants and codes of the two-way shared stack.
`default_nettype none
package tws_pkg;
    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int WORD_W   = 32;
    localparam int CNT_W    = 11;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;

    // Operation codes; codes beyond query behave as query.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_LEFT  = 3'd0,
        OP_PUSH_RIGHT = 3'd1,
        OP_POP_LEFT   = 3'd2,
        OP_POP_RIGHT  = 3'd3,
        OP_QUERY      = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
    } ctrl_cmd_t;
endpackage
`default_nettype wire

// ----- hdl/tws_item_if.sv -----
// Input channel interface: operation and word with valid/ready handshake.
`default_nettype none
interface tws_item_if;
    import tws_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface
`default_nettype wire

// ----- hdl/tws_result_if.sv -----
// Result channel interface: status, both tops and both sizes with valid/ready.
`default_nettype none
interface tws_result_if;
    import tws_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] left_top;
    logic                     left_valid;
    logic signed [WORD_W-1:0] right_top;
    logic                     right_valid;
    logic [CNT_W-1:0]         left_size;
    logic [CNT_W-1:0]         right_size;

    modport source (output valid, output status, output left_top, output left_valid,
                    output right_top, output right_valid, output left_size,
                    output right_size, input ready);
    modport sink   (input valid, input status, input left_top, input left_valid,
                    input right_top, input right_valid, input left_size,
                    input right_size, output ready);
endinterface
`default_nettype wire

// ----- hdl/tws_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module tws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered reads; read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule
`default_nettype wire

// ----- hdl/tws_datapath.sv -----
// Datapath: capacity register, stack counters, word store and result fields.
`default_nettype none
module tws_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tws_pkg::ctrl_cmd_t               cmd,
    input  wire logic                             cfg_we,
    input  wire logic [tws_pkg::APB_DW-1:0]       cfg_wdata,
    output logic      [tws_pkg::APB_DW-1:0]       cfg_rdata,
    input  wire logic [tws_pkg::OP_W-1:0]         operation,
    input  wire logic signed [tws_pkg::WORD_W-1:0] value,
    output logic      [tws_pkg::STATUS_W-1:0]     status,
    output logic signed [tws_pkg::WORD_W-1:0]     left_top,
    output logic                                  left_valid,
    output logic signed [tws_pkg::WORD_W-1:0]     right_top,
    output logic                                  right_valid,
    output logic      [tws_pkg::CNT_W-1:0]        left_size,
    output logic      [tws_pkg::CNT_W-1:0]        right_size
);
    import tws_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]    cap_reg, cap_next;
    logic [CNT_W-1:0]    left_cnt_reg, left_cnt_next;
    logic [CNT_W-1:0]    right_cnt_reg, right_cnt_next;
    logic [OP_W-1:0]     op_reg;
    logic [WORD_W-1:0]   value_reg;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [CNT_W-1:0]    usable;
    logic                full;
    logic [CNT_W-1:0]    right_wr_idx;
    logic [CNT_W-1:0]    left_rd_idx;
    logic [CNT_W-1:0]    right_rd_idx;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [WORD_W-1:0]   rdata_a;
    logic [WORD_W-1:0]   rdata_b;

    // Usable entries are the capacity limited to the store depth.
    assign usable = (cap_reg > DEPTH_CNT) ? DEPTH_CNT : cap_reg;
    assign full   = ({1'b0, left_cnt_reg} + {1'b0, right_cnt_reg}) >= {1'b0, usable};

    // Store indexes for the right push and for both top reads.
    assign right_wr_idx = usable - right_cnt_reg - CNT_W'(1);
    assign left_rd_idx  = left_cnt_reg - CNT_W'(1);
    assign right_rd_idx = usable - right_cnt_reg;

    // Capacity write and operation decode: counter updates, status and store write.
    always_comb
    begin
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        status_next    = status_reg;
        cap_next       = cap_reg;
        we             = 1'b0;
        waddr          = left_cnt_reg[ADDR_W-1:0];
        if (cfg_we)
        begin
            cap_next       = cfg_wdata[CNT_W-1:0];
            left_cnt_next  = '0;
            right_cnt_next = '0;
        end
        else if (cmd.exec)
        begin
            status_next = ST_DONE;
            case (op_reg)
                OP_PUSH_LEFT:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        we            = 1'b1;
                        waddr         = left_cnt_reg[ADDR_W-1:0];
                        left_cnt_next = left_cnt_reg + CNT_W'(1);
                    end
                end
                OP_PUSH_RIGHT:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        we             = 1'b1;
                        waddr          = right_wr_idx[ADDR_W-1:0];
                        right_cnt_next = right_cnt_reg + CNT_W'(1);
                    end
                end
                OP_POP_LEFT:
                begin
                    if (left_cnt_reg == '0)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        left_cnt_next = left_cnt_reg - CNT_W'(1);
                    end
                end
                OP_POP_RIGHT:
                begin
                    if (right_cnt_reg == '0)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        right_cnt_next = right_cnt_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= DEPTH_CNT;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            status_reg    <= ST_DONE;
        end
        else
        begin
            cap_reg       <= cap_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
            status_reg    <= status_next;
        end
    end

    // Item capture on an accepted transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            value_reg <= value;
        end
    end

    // Shared word store.
    tws_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (value_reg),
        .re      (cmd.read),
        .raddr_a (left_rd_idx[ADDR_W-1:0]),
        .raddr_b (right_rd_idx[ADDR_W-1:0]),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Result fields; an empty side reports a zero top.
    assign left_valid  = (left_cnt_reg != '0);
    assign right_valid = (right_cnt_reg != '0);
    assign left_top    = left_valid ? rdata_a : '0;
    assign right_top   = (right_valid && (right_cnt_reg <= usable)) ? rdata_b : '0;
    assign left_size   = left_cnt_reg;
    assign right_size  = right_cnt_reg;
    assign status      = status_reg;
    assign cfg_rdata   = {{(APB_DW-CNT_W){1'b0}}, cap_reg};
endmodule
`default_nettype wire

// ----- hdl/tws_ctrl.sv -----
// Controller state machine that sequences capture, execute, read and result.
`default_nettype none
module tws_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output tws_pkg::ctrl_cmd_t cmd
);
    import tws_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.read    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_READ:
            begin
                cmd.read = 1'b1;
            end
            S_RESP:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- hdl/two_way_shared_stack_top.sv -----
// An accepted input transfer is captured; the controller then executes the operation,
// reads both tops from the single word store and offers the result; no new input is
// accepted until that result is taken.
// Reset: rst_n is asynchronous and active low; it empties both stacks and sets
// capacity to 1024. Store contents are not cleared, as an empty side reports a zero top.
`default_nettype none
`include "assert_macros.svh"
module two_way_shared_stack_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tws_pkg::APB_AW-1:0]  paddr,
    input  wire logic [tws_pkg::APB_DW-1:0]  pwdata,
    output logic      [tws_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    tws_item_if.sink                         item_in,
    tws_result_if.source                     result_out
);
    import tws_pkg::*;

    ctrl_cmd_t      cmd;
    logic           cfg_we;
    logic [CNT_W:0] total_size;
    logic           flags_agree;

    // The only register sits at address zero; writes elsewhere are ignored.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == '0);

    tws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .cmd       (cmd)
    );

    tws_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (pwdata),
        .cfg_rdata   (prdata),
        .operation   (item_in.operation),
        .value       (item_in.value),
        .status      (result_out.status),
        .left_top    (result_out.left_top),
        .left_valid  (result_out.left_valid),
        .right_top   (result_out.right_top),
        .right_valid (result_out.right_valid),
        .left_size   (result_out.left_size),
        .right_size  (result_out.right_size)
    );

    // Combined size and flag agreement, watched by the assertions below.
    assign total_size  = {1'b0, result_out.left_size} + {1'b0, result_out.right_size};
    assign flags_agree = (result_out.left_valid == (result_out.left_size != '0)) &&
                         (result_out.right_valid == (result_out.right_size != '0));

    // One item in flight: never ready for input while a result is offered.
    `TWS_ASSERT_ALWAYS(a_one_in_flight, clk, rst_n, !(item_in.ready && result_out.valid))
    // An accepted transfer never shows a result in the following cycle.
    `TWS_ASSERT_NEXT(a_no_early_result, clk, rst_n, item_in.valid && item_in.ready, !result_out.valid)
    // The two stacks together never hold more than the store depth.
    `TWS_ASSERT_ALWAYS(a_size_bound, clk, rst_n, total_size <= (CNT_W + 1)'(DEPTH))
    // Valid flags agree with the reported sizes while a result is offered.
    `TWS_ASSERT_ALWAYS(a_valid_flags, clk, rst_n, !result_out.valid || flags_agree)
endmodule
`default_nettype wire
